// ===== hdl/mzts_pkg.sv =====
// Package with payload types, register indexes and constants for the motion zone scorer.
package mzts_pkg;

  localparam int unsigned MaxDim   = 4096;
  localparam int unsigned PosW     = 12;
  localparam int unsigned CountW   = 25;
  localparam int unsigned SumW     = 40;
  localparam int unsigned CfgDataW = 25;
  localparam int unsigned CfgIdxW  = 3;

  localparam logic [CfgIdxW-1:0] RegDiffThres = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMinAlarm  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMaxAlarm  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegWidth     = 3'd3;
  localparam logic [CfgIdxW-1:0] RegHeight    = 3'd4;

  typedef struct packed {
    logic [7:0]      delta;
    logic [15:0]     variance_high;
    logic            in_mask;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            last_pixel;
  } pix_t;

  typedef struct packed {
    logic              over_threshold;
    logic              frame_done;
    logic              alarm;
    logic [7:0]        score;
    logic [CountW-1:0] alarm_pixels;
    logic [PosW-1:0]   box_min_x;
    logic [PosW-1:0]   box_min_y;
    logic [PosW-1:0]   box_max_x;
    logic [PosW-1:0]   box_max_y;
  } res_t;

  // Item passed from the classifier to the accumulator.
  typedef struct packed {
    logic            over;
    logic [7:0]      delta;
    logic [PosW-1:0] pos_x;
    logic [PosW-1:0] pos_y;
    logic            last_pixel;
  } cls_t;

  typedef enum logic [1:0] {
    BkIdle,
    BkDiv,
    BkSqrt,
    BkOut
  } bk_state_e;

  function automatic logic [PosW-1:0] start_min(input logic [12:0] size);
    logic [12:0] m;
    begin
      m = size - 13'd1;
      if (size == 13'd0) begin
        start_min = '0;
      end else if (m > 13'(MaxDim - 1)) begin
        start_min = PosW'(MaxDim - 1);
      end else begin
        start_min = m[PosW-1:0];
      end
    end
  endfunction

endpackage

// ===== hdl/mzts_front.sv =====
// Front end: bit-serial variance root and threshold test for each pixel.
module mzts_front import mzts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] diff_thres_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pix_t        in_data_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output cls_t        q_data_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [3:0]  step_q, step_d;
  logic [15:0] rem_q, rem_d;
  logic [7:0]  root_q, root_d;
  logic [17:0] acc_q, acc_d;
  pix_t        pix_q, pix_d;
  logic [17:0] trial;
  logic [17:0] rem_sh;
  logic [23:0] prod;

  // Restoring square root of the 16-bit variance, one result bit per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    rem_d  = rem_q;
    root_d = root_q;
    acc_d  = acc_q;
    pix_d  = pix_q;
    rem_sh = {acc_q[15:0], rem_q[15:14]};
    trial  = {8'd0, root_q, 2'b01};
    prod   = {8'd0, diff_thres_i} * {16'd0, root_q};
    if (!busy_q && in_valid_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      pix_d  = in_data_i;
      rem_d  = in_data_i.variance_high;
      root_d = '0;
      acc_d  = '0;
      step_d = '0;
    end else if (busy_q && !done_q) begin
      rem_d = {rem_q[13:0], 2'b00};
      if (rem_sh >= trial) begin
        acc_d  = rem_sh - trial;
        root_d = {root_q[6:0], 1'b1};
      end else begin
        acc_d  = rem_sh;
        root_d = {root_q[6:0], 1'b0};
      end
      step_d = step_q + 4'd1;
      if (step_q == 4'd7) begin
        done_d = 1'b1;
      end
    end else if (done_q && q_ready_i) begin
      busy_d = 1'b0;
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    acc_q  <= acc_d;
    pix_q  <= pix_d;
  end

  assign in_ready_o          = !busy_q;
  assign q_valid_o           = done_q;
  assign q_data_o.over       = pix_q.in_mask && ({8'd0, pix_q.delta, 8'd0} > prod);
  assign q_data_o.delta      = pix_q.delta;
  assign q_data_o.pos_x      = pix_q.pos_x;
  assign q_data_o.pos_y      = pix_q.pos_y;
  assign q_data_o.last_pixel = pix_q.last_pixel;

endmodule

// ===== hdl/mzts_fifo.sv =====
// Two-entry queue between the classifier and the accumulator.
module mzts_fifo import mzts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic wr_valid_i,
  output logic wr_ready_o,
  input  cls_t wr_data_i,
  output logic rd_valid_o,
  input  logic rd_ready_i,
  output cls_t rd_data_o
);

  cls_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       wr, rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr         = wr_valid_i && wr_ready_o;
  assign rd         = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= wr_data_i;
  end

endmodule

// ===== hdl/mzts_back.sv =====
// Back end: frame accumulation, end-of-frame divide and root, result register.
module mzts_back import mzts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [15:0]         diff_thres_o,
  input  logic                q_valid_i,
  output logic                q_ready_o,
  input  cls_t                q_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                out_data_o
);

  bk_state_e state_q, state_d;

  logic [15:0]       thres_q;
  logic [CountW-1:0] min_q, max_q, cnt_q;
  logic [12:0]       width_q, height_q;
  logic [SumW-1:0]   sum_q;
  logic [PosW-1:0]   lx_q, ly_q, hx_q, hy_q;

  logic [SumW-1:0]   quo_q;
  logic [CountW:0]   drem_q;
  logic [5:0]        it_q;
  logic [SumW-1:0]   srem_q;
  logic [SumW-1:0]   sres_q;
  logic [SumW-1:0]   sbit_q;

  logic              ovalid_q, ovalid_d;
  res_t              odata_q, odata_d;

  logic              take;
  logic [CountW:0]   dshift;
  logic [SumW-1:0]   sq;
  logic [SumW:0]     nsum;
  logic              sum_last;
  logic [SumW-1:0]   sroot;
  logic              alarm;
  logic              start_fin;

  assign diff_thres_o = thres_q;
  assign q_ready_o    = (state_q == BkIdle) && (!ovalid_q || out_ready_i);
  assign take         = q_valid_i && q_ready_o;
  assign start_fin    = take && q_data_i.last_pixel;
  assign sq           = SumW'(q_data_i.delta * q_data_i.delta);
  assign nsum         = {1'b0, sum_q} + {1'b0, sq};
  assign sum_last     = 1'b0;
  assign dshift       = {drem_q[CountW-1:0], quo_q[SumW-1]};
  assign sroot        = sres_q;
  assign alarm        = (min_q != '0) && (cnt_q >= min_q) && (max_q != '0) && (cnt_q <= max_q);
  assign ovalid_d     = (ovalid_q && !out_ready_i)
                      || (take && (!q_data_i.last_pixel || state_d == BkIdle))
                      || (state_q == BkOut);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BkIdle: if (start_fin && (cnt_q != '0 || q_data_i.over)) state_d = BkDiv;
      BkDiv:  if (it_q == 6'(SumW - 1)) state_d = BkSqrt;
      BkSqrt: if (sbit_q == '0) state_d = BkOut;
      BkOut:  state_d = BkIdle;
      default: state_d = BkIdle;
    endcase
  end

  always_comb begin
    odata_d = odata_q;
    if (take) begin
      odata_d                = '0;
      odata_d.over_threshold = q_data_i.over;
      if (q_data_i.last_pixel) begin
        odata_d.frame_done = 1'b1;
        odata_d.box_min_x  = q_data_i.over && q_data_i.pos_x < lx_q ? q_data_i.pos_x : lx_q;
        odata_d.box_min_y  = q_data_i.over && q_data_i.pos_y < ly_q ? q_data_i.pos_y : ly_q;
        odata_d.box_max_x  = q_data_i.over && q_data_i.pos_x > hx_q ? q_data_i.pos_x : hx_q;
        odata_d.box_max_y  = q_data_i.over && q_data_i.pos_y > hy_q ? q_data_i.pos_y : hy_q;
      end
    end
    if (state_q == BkOut) begin
      odata_d.score        = (sroot > SumW'(8'hff) || sum_last) ? 8'hff : sroot[7:0];
      odata_d.alarm        = alarm;
      odata_d.alarm_pixels = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BkIdle;
      thres_q  <= 16'd256;
      min_q    <= '0;
      max_q    <= '0;
      width_q  <= 13'd640;
      height_q <= 13'd480;
      cnt_q    <= '0;
      sum_q    <= '0;
      lx_q     <= start_min(13'd640);
      ly_q     <= start_min(13'd480);
      hx_q     <= '0;
      hy_q     <= '0;
      ovalid_q <= 1'b0;
      it_q     <= '0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDiffThres: thres_q <= cfg_data_i[15:0];
          RegMinAlarm:  min_q <= cfg_data_i;
          RegMaxAlarm:  max_q <= cfg_data_i;
          RegWidth: begin
            width_q <= cfg_data_i[12:0];
            if (cnt_q == '0) lx_q <= start_min(cfg_data_i[12:0]);
          end
          RegHeight: begin
            height_q <= cfg_data_i[12:0];
            if (cnt_q == '0) ly_q <= start_min(cfg_data_i[12:0]);
          end
          default: ;
        endcase
      end
      if (take) begin
        if (q_data_i.over) begin
          if (cnt_q != '1) cnt_q <= cnt_q + 1'b1;
          sum_q <= nsum[SumW] ? '1 : nsum[SumW-1:0];
          if (q_data_i.pos_x < lx_q) lx_q <= q_data_i.pos_x;
          if (q_data_i.pos_y < ly_q) ly_q <= q_data_i.pos_y;
          if (q_data_i.pos_x > hx_q) hx_q <= q_data_i.pos_x;
          if (q_data_i.pos_y > hy_q) hy_q <= q_data_i.pos_y;
        end
      end
      if (state_q == BkIdle && state_d == BkDiv) it_q <= '0;
      if (state_q == BkDiv) it_q <= it_q + 6'd1;
      if (state_q == BkOut || (start_fin && state_d == BkIdle)) begin
        cnt_q <= '0;
        sum_q <= '0;
        lx_q  <= start_min(width_q);
        ly_q  <= start_min(height_q);
        hx_q  <= '0;
        hy_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    odata_q <= odata_d;
    if (state_q == BkIdle && state_d == BkDiv) begin
      quo_q  <= nsum[SumW] ? '1 : (q_data_i.over ? nsum[SumW-1:0] : sum_q);
      drem_q <= '0;
    end
    if (state_q == BkDiv) begin
      if (dshift >= {1'b0, cnt_q}) begin
        drem_q <= dshift - {1'b0, cnt_q};
        quo_q  <= {quo_q[SumW-2:0], 1'b1};
      end else begin
        drem_q <= dshift;
        quo_q  <= {quo_q[SumW-2:0], 1'b0};
      end
      if (it_q == 6'(SumW - 1)) begin
        sres_q <= '0;
        sbit_q <= SumW'(1) << (SumW - 2);
      end
    end
    if (state_q == BkDiv && it_q == 6'(SumW - 1)) begin
      srem_q <= (dshift >= {1'b0, cnt_q}) ? {quo_q[SumW-2:0], 1'b1} : {quo_q[SumW-2:0], 1'b0};
    end
    if (state_q == BkSqrt && sbit_q != '0) begin
      if (srem_q >= sres_q + sbit_q) begin
        srem_q <= srem_q - (sres_q + sbit_q);
        sres_q <= (sres_q >> 1) + sbit_q;
      end else begin
        sres_q <= sres_q >> 1;
      end
      sbit_q <= sbit_q >> 2;
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

endmodule

// ===== hdl/motion_zone_threshold_score.sv =====
// Top level of the motion zone threshold scorer.
// The front end takes no new pixel until its eight-step variance root result is taken.
// A frame with hits has its last pixel run a 40-step divider and 20-step root before output.
// Reset is asynchronous, active low; registers take their defaults and the frame state clears.
module motion_zone_threshold_score import mzts_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output res_t                out_data_o
);

  logic        fq_valid, fq_ready, bq_valid, bq_ready;
  cls_t        fq_data, bq_data;
  logic [15:0] thres;

  mzts_front u_front (
    .clk_i, .rst_ni,
    .diff_thres_i(thres),
    .in_valid_i, .in_ready_o, .in_data_i,
    .q_valid_o(fq_valid), .q_ready_i(fq_ready), .q_data_o(fq_data)
  );

  mzts_fifo u_fifo (
    .clk_i, .rst_ni,
    .wr_valid_i(fq_valid), .wr_ready_o(fq_ready), .wr_data_i(fq_data),
    .rd_valid_o(bq_valid), .rd_ready_i(bq_ready), .rd_data_o(bq_data)
  );

  mzts_back u_back (
    .clk_i, .rst_ni,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .diff_thres_o(thres),
    .q_valid_i(bq_valid), .q_ready_o(bq_ready), .q_data_i(bq_data),
    .out_valid_o, .out_ready_i, .out_data_o
  );

`ifndef SYNTHESIS
  a_done_needs_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.frame_done |-> out_data_o.alarm_pixels == '0)
    else $error("summary field set on a non-final beat");
  a_alarm_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.alarm |-> out_data_o.alarm_pixels != '0)
    else $error("alarm raised with zero count");
`endif

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the motion zone threshold scorer.
`timescale 1ns / 100ps

class frame_score_board;
  mzts_pkg::res_t pending[$];
  int unsigned    mismatches;
  int unsigned    frames_seen;
  int unsigned    hits_seen;
  int unsigned    alarms_seen;
  logic [15:0]    thres;
  logic [24:0]    min_pix;
  logic [24:0]    max_pix;
  logic [12:0]    width;
  logic [12:0]    height;
  logic [24:0]    hits;
  logic [39:0]    sq_sum;
  logic [11:0]    lo_x;
  logic [11:0]    lo_y;
  logic [11:0]    hi_x;
  logic [11:0]    hi_y;

  function new();
    thres = 16'd256;
    min_pix = '0;
    max_pix = '0;
    width = 13'd640;
    height = 13'd480;
    mismatches = 0;
    frames_seen = 0;
    hits_seen = 0;
    alarms_seen = 0;
    clear_frame();
  endfunction

  function logic [11:0] box_start(logic [12:0] size);
    if (size == 0) return '0;
    if (size - 1 > 4095) return 12'hfff;
    return 12'(size - 1);
  endfunction

  function logic [63:0] int_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function void clear_frame();
    hits = '0;
    sq_sum = '0;
    lo_x = box_start(width);
    lo_y = box_start(height);
    hi_x = '0;
    hi_y = '0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [24:0] val);
    case (idx)
      mzts_pkg::RegDiffThres: thres = val[15:0];
      mzts_pkg::RegMinAlarm: min_pix = val;
      mzts_pkg::RegMaxAlarm: max_pix = val;
      mzts_pkg::RegWidth: begin
        width = val[12:0];
        if (hits == 0) lo_x = box_start(width);
      end
      mzts_pkg::RegHeight: begin
        height = val[12:0];
        if (hits == 0) lo_y = box_start(height);
      end
      default: ;
    endcase
  endfunction

  function void note_pixel(mzts_pkg::pix_t p);
    mzts_pkg::res_t r;
    logic [31:0]    base;
    logic [63:0]    sq;
    logic [63:0]    mean;
    logic           over;
    r = '0;
    over = 0;
    if (p.in_mask) begin
      base = 32'(int_root(64'(p.variance_high)));
      if ((32'(p.delta) << 8) > 32'(thres) * base) over = 1;
    end
    if (over) begin
      sq = 64'(p.delta) * 64'(p.delta);
      hits_seen++;
      if (hits != 25'h1ffffff) hits = hits + 1;
      if (64'(sq_sum) > 64'hff_ffff_ffff - sq) sq_sum = '1;
      else sq_sum = 40'(64'(sq_sum) + sq);
      if (p.pos_x < lo_x) lo_x = p.pos_x;
      if (p.pos_y < lo_y) lo_y = p.pos_y;
      if (p.pos_x > hi_x) hi_x = p.pos_x;
      if (p.pos_y > hi_y) hi_y = p.pos_y;
    end
    r.over_threshold = over;
    if (p.last_pixel) begin
      frames_seen++;
      if (hits != 0) begin
        mean = int_root(64'(sq_sum) / 64'(hits));
        r.score = (mean > 255) ? 8'hff : mean[7:0];
      end
      r.frame_done = 1;
      r.alarm = min_pix != 0 && hits >= min_pix && max_pix != 0 && hits <= max_pix;
      if (r.alarm) alarms_seen++;
      r.alarm_pixels = hits;
      r.box_min_x = lo_x;
      r.box_min_y = lo_y;
      r.box_max_x = hi_x;
      r.box_max_y = hi_y;
      clear_frame();
    end
    pending.push_back(r);
  endfunction

  function void check_result(mzts_pkg::res_t got);
    mzts_pkg::res_t exp_r;
    if (pending.size() == 0) begin
      report_mismatch("unexpected beat", 0, got);
      return;
    end
    exp_r = pending.pop_front();
    if (got.over_threshold !== exp_r.over_threshold) report_mismatch("over", exp_r, got);
    if (got.frame_done !== exp_r.frame_done) report_mismatch("frame_done", exp_r, got);
    if (got.alarm !== exp_r.alarm) report_mismatch("alarm", exp_r, got);
    if (got.score !== exp_r.score) report_mismatch("score", exp_r, got);
    if (got.alarm_pixels !== exp_r.alarm_pixels) report_mismatch("count", exp_r, got);
    if (got.box_min_x !== exp_r.box_min_x) report_mismatch("box_min_x", exp_r, got);
    if (got.box_min_y !== exp_r.box_min_y) report_mismatch("box_min_y", exp_r, got);
    if (got.box_max_x !== exp_r.box_max_x) report_mismatch("box_max_x", exp_r, got);
    if (got.box_max_y !== exp_r.box_max_y) report_mismatch("box_max_y", exp_r, got);
  endfunction

  function void report_mismatch(string what, mzts_pkg::res_t exp_r, mzts_pkg::res_t got);
    mismatches++;
    if (mismatches <= 30)
      $display("mismatch %s: expected %h got %h at %0t", what, exp_r, got, $realtime);
  endfunction
endclass

module tb_top;
  import mzts_pkg::*;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_we_i = 0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                in_valid_i = 0;
  logic                in_ready_o;
  pix_t                in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 0;
  res_t                out_data_o;

  frame_score_board board = new();
  int unsigned idle_cycles = 0;
  int unsigned stall_left = 0;
  bit          calm = 0;
  int unsigned frame_len;

  localparam int unsigned WatchLimit = 20000;

  always #4 clk_i = ~clk_i;

  motion_zone_threshold_score dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("TB_ERROR");
        $finish;
      end
      if (calm) begin
        out_ready_i <= 1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready_i <= 0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(1, 12) - 1;
        out_ready_i <= 0;
      end else begin
        out_ready_i <= 1;
      end
    end
  end

  task automatic send_pixel(pix_t p);
    int unsigned gap;
    cfg_we_i <= 0;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_pixel(p);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [24:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    board.write_reg(idx, val);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  function automatic pix_t random_pixel(bit last);
    pix_t p;
    p.delta = $urandom_range(0, 255);
    p.variance_high = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
    p.in_mask = $urandom_range(0, 3) != 0;
    p.pos_x = 12'($urandom);
    p.pos_y = 12'($urandom);
    p.last_pixel = last;
    return p;
  endfunction

  task automatic random_frames(int unsigned pixels);
    int unsigned sent;
    sent = 0;
    while (sent < pixels) begin
      frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      for (int unsigned k = 1; k <= frame_len; k++) begin
        send_pixel(random_pixel(k == frame_len || $urandom_range(0, 60) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    pix_t p;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: extremes with reset settings, then mid-frame size writes.
    p = '{delta: 8'hff, variance_high: 16'h0, in_mask: 1, pos_x: 12'hfff, pos_y: 12'h0,
          last_pixel: 0};
    send_pixel(p);
    p = '{delta: 8'h0, variance_high: 16'h0, in_mask: 1, pos_x: 12'h0, pos_y: 12'hfff,
          last_pixel: 0};
    send_pixel(p);
    p = '{delta: 8'hff, variance_high: 16'hffff, in_mask: 1, pos_x: 12'h0, pos_y: 12'hfff,
          last_pixel: 0};
    send_pixel(p);
    p = '{delta: 8'hff, variance_high: 16'h0, in_mask: 0, pos_x: 12'h5, pos_y: 12'h5,
          last_pixel: 1};
    send_pixel(p);
    p = '{delta: 8'h10, variance_high: 16'h0, in_mask: 0, pos_x: 12'h0, pos_y: 12'h0,
          last_pixel: 1};
    send_pixel(p);
    drain();
    write_reg(RegWidth, 25'd0);
    write_reg(RegHeight, 25'd8191);
    write_reg(RegMinAlarm, 25'd1);
    write_reg(RegMaxAlarm, 25'h1000000);
    write_reg(3'd7, 25'h1ffffff);
    write_reg(RegDiffThres, 25'd0);
    p = '{delta: 8'h1, variance_high: 16'hffff, in_mask: 1, pos_x: 12'h7, pos_y: 12'h9,
          last_pixel: 1};
    send_pixel(p);
    drain();
    write_reg(RegWidth, 25'd4097);
    write_reg(RegHeight, 25'd1);
    write_reg(RegDiffThres, 25'hffff);
    p = '{delta: 8'hff, variance_high: 16'h0, in_mask: 1, pos_x: 12'h3, pos_y: 12'h4,
          last_pixel: 1};
    send_pixel(p);
    drain();
    write_reg(RegDiffThres, 25'd64);
    p = '{delta: 8'h80, variance_high: 16'd4, in_mask: 1, pos_x: 12'd20, pos_y: 12'd30,
          last_pixel: 0};
    send_pixel(p);
    drain();
    write_reg(RegWidth, 25'd100);
    write_reg(RegHeight, 25'd4096);
    p.last_pixel = 1;
    send_pixel(p);
    drain();

    // Random frames under a set of threshold and alarm settings.
    for (int unsigned ph = 0; ph < 6; ph++) begin
      write_reg(RegDiffThres, (ph == 5) ? 25'hffff : 25'($urandom_range(16, 1200)));
      write_reg(RegMinAlarm, (ph == 0) ? 25'd0 : 25'($urandom_range(1, 6)));
      write_reg(RegMaxAlarm, (ph == 3) ? 25'h1ffffff : 25'($urandom_range(0, 25)));
      write_reg(RegWidth, 25'($urandom_range(1, 4096)));
      write_reg(RegHeight, 25'($urandom_range(1, 4096)));
      if (ph == 5) calm = 1;
      random_frames(230);
      p = random_pixel(1);
      send_pixel(p);
      drain();
    end

    $display("Covered %0d frames, %0d over-threshold pixels, %0d alarms.",
             board.frames_seen, board.hits_seen, board.alarms_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/mzts_pkg.sv
hdl/mzts_front.sv
hdl/mzts_fifo.sv
hdl/mzts_back.sv
hdl/motion_zone_threshold_score.sv
verif/tb_top.sv
